// ===== rtl/core/tach_pkg.sv =====
// Package for the tachometer RPM filter core: register indexes, field widths,
// arithmetic constants and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
package tach_pkg;

   // Configuration register indexes
   localparam logic [2:0] REG_MIN_RPM     = 3'd0;
   localparam logic [2:0] REG_MAX_RPM     = 3'd1;
   localparam logic [2:0] REG_UPD_PERIOD  = 3'd2;
   localparam logic [2:0] REG_FILTER_FREQ = 3'd3;
   localparam logic [2:0] REG_CHAN_EN     = 3'd4;

   // Input item kinds
   localparam logic ACT_EDGE   = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   localparam int DEF_CHANNELS = 3;
   localparam int ENABLE_W     = 3;
   localparam int CHAN_W       = 2;
   localparam int TIME_W       = 32;
   localparam int RPM_W        = 26;
   localparam int FILT_W       = 34;
   localparam int ALPHA_W      = 17;
   localparam int K_W          = 44;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 20;
   localparam int DIV_NUM_W    = 35;
   localparam int DIV_DEN_W    = 34;

   localparam logic [DIV_NUM_W-1:0] RPM_NUMER  = 35'd60000000;
   localparam logic [TIME_W-1:0]    TIMEOUT_US = 32'd1000000;
   localparam logic [13:0]          SPIKE_SLOPE = 14'd10000;
   localparam logic [16:0]          TWOPI_SCALED = 17'd110535;
   localparam logic [ALPHA_W-1:0]   ALPHA_ONE = 17'd65536;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic edge_wr;
      logic ch_clear;
      logic k_mul;
      logic x_mul;
      logic div_alpha;
      logic alpha_load;
      logic div_speed;
      logic speed_load;
      logic lim_mul;
      logic decide;
      logic filt1;
      logic filt2;
      logic filt3;
      logic out_load;
      logic ch_next;
      logic upd_time;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_update;
      logic drop;
      logic div_done;
      logic ch_en;
      logic ch_end;
      logic rest_none;
      logic period_zero;
      logic skip_filter;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/core/tach_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the alpha and
// speed computations. Depends on tach_pkg.
`timescale 1ns / 1ps
module tach_div
   import tach_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] numer,
   input  logic [DIV_DEN_W-1:0] denom,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] shf_ff, shf_in;
   logic [DIV_NUM_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] rem_sh;
   logic                 q_bit;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      rem_sh  = {rem_ff[DIV_NUM_W-2:0], shf_ff[DIV_NUM_W-1]};
      q_bit   = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      shf_in  = shf_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_NUM_W);
         shf_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = q_bit ? rem_sh - {1'b0, den_ff} : rem_sh;
         shf_in = {shf_ff[DIV_NUM_W-2:0], q_bit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shf_ff <= shf_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = shf_ff;
endmodule

// ===== rtl/core/tach_dp.sv =====
// Datapath of the tachometer core: configuration registers, per-channel
// state, multipliers, the shared divider and the result register.
// Depends on tach_pkg and tach_div.
`timescale 1ns / 1ps
module tach_dp
   import tach_pkg::*;
#(
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  in_action,
   input  logic [CHAN_W-1:0]     in_channel,
   input  logic [TIME_W-1:0]     in_time,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [79:0]           rsp_tdata,
   output logic                  rsp_tlast
);
   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Configuration registers
   logic [15:0]         min_ff, max_ff;
   logic [19:0]         updp_ff, ffreq_ff;
   logic [ENABLE_W-1:0] en_ff;

   // Captured item
   logic              act_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic [TIME_W-1:0] now_ff;

   // Per-channel and shared state
   logic [TIME_W-1:0] edge_ff   [CHANNELS];
   logic [TIME_W-1:0] period_ff [CHANNELS];
   logic [RPM_W-1:0]  raw_ff    [CHANNELS];
   logic [FILT_W-1:0] filt_ff   [CHANNELS];
   logic [TIME_W-1:0] last_upd_ff;
   logic [RPM_W-1:0]  shared_ff;

   // Working registers
   logic [IW-1:0]      cnt_ff;
   logic [K_W-1:0]     k_ff;
   logic [DIV_DEN_W-1:0] d_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [RPM_W-1:0]   speed_ff;
   logic [45:0]        lim_ff;
   logic [RPM_W-1:0]   tgt_ff;
   logic [50:0]        p1_ff, p2_ff;

   // Result register
   logic              ovalid_ff;
   logic [CHAN_W-1:0] ochan_ff;
   logic [RPM_W-1:0]  oraw_ff, ofilt_ff, oshared_ff;
   logic              olast_ff;

   logic [IW-1:0]        idx;
   logic [TIME_W-1:0]    dt, age;
   logic [51:0]          k_prod;
   logic [60:0]          x_prod;
   logic [DIV_NUM_W-1:0] div_num, div_q;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_start, div_done;
   logic [CHANNELS-1:0]  en_vec;
   logic                 rest_hi;
   logic [RPM_W-1:0]     raw_cur;
   logic [RPM_W-1:0]     diff;
   logic                 spike, hold;
   logic [51:0]          acc;
   logic [FILT_W-1:0]    f_new;
   logic                 chan_ok;

   // One index serves edge writes and the channel sweep.
   assign idx     = cmd.edge_wr ? IW'(chan_ff) : cnt_ff;
   assign chan_ok = 32'(chan_ff) < CHANNELS;
   assign dt      = now_ff - last_upd_ff;
   assign age     = now_ff - edge_ff[idx];
   assign raw_cur = raw_ff[idx];
   assign diff    = speed_ff - raw_cur;
   assign k_prod  = 52'(ffreq_ff) * 52'(dt);
   assign x_prod  = 61'(k_ff) * 61'(TWOPI_SCALED);

   // Enable bits exist only for the first channels.
   for (genvar g = 0; g < CHANNELS; g++) begin : g_en
      if (g < ENABLE_W) begin : g_on
         assign en_vec[g] = en_ff[g];
      end else begin : g_off
         assign en_vec[g] = 1'b0;
      end
   end

   always_comb begin
      rest_hi = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (i > int'(cnt_ff)) begin
            rest_hi = rest_hi | en_vec[i];
         end
      end
   end

   // Spike rejection and maximum hold decide whether the filter runs.
   assign spike = (speed_ff > RPM_W'(min_ff)) && (speed_ff > raw_cur) &&
                  ((dt == '0) || (46'(diff) > lim_ff));
   assign hold  = (speed_ff >= RPM_W'(min_ff)) && (max_ff != '0) &&
                  (speed_ff > RPM_W'(max_ff));

   assign acc   = 52'(p1_ff) + 52'(p2_ff) + 52'(32768);
   assign f_new = acc[FILT_W+15:16];

   // Shared divider operands
   assign div_start = cmd.div_alpha | cmd.div_speed;
   assign div_num   = cmd.div_alpha ? (35'(64'h1_0000_0000) + 35'(d_ff[DIV_DEN_W-1:1]))
                                    : RPM_NUMER;
   assign div_den   = cmd.div_alpha ? d_ff : DIV_DEN_W'(period_ff[idx]);

   tach_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= '0;
         max_ff   <= '0;
         updp_ff  <= '0;
         ffreq_ff <= '0;
         en_ff    <= '0;
      end else if (csr_we) begin
         case (csr_idx)
            REG_MIN_RPM:     min_ff   <= csr_wdata[15:0];
            REG_MAX_RPM:     max_ff   <= csr_wdata[15:0];
            REG_UPD_PERIOD:  updp_ff  <= csr_wdata;
            REG_FILTER_FREQ: ffreq_ff <= csr_wdata;
            REG_CHAN_EN:     en_ff    <= csr_wdata[ENABLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Item capture and working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= in_action;
         chan_ff <= in_channel;
         now_ff  <= in_time;
      end
      if (cmd.k_mul) begin
         k_ff <= (|k_prod[51:K_W]) ? '1 : k_prod[K_W-1:0];
      end
      if (cmd.x_mul) begin
         d_ff <= DIV_DEN_W'(x_prod[60:28]) + DIV_DEN_W'(ALPHA_ONE);
      end
      if (cmd.alpha_load) begin
         alpha_ff <= (ffreq_ff == '0) ? '0 : div_q[ALPHA_W-1:0];
      end
      if (cmd.speed_load) begin
         if ((period_ff[idx] == '0) || (age > TIMEOUT_US)) begin
            speed_ff <= '0;
         end else begin
            speed_ff <= div_q[RPM_W-1:0];
         end
      end
      if (cmd.lim_mul) begin
         lim_ff <= 46'(dt) * 46'(SPIKE_SLOPE);
      end
      if (cmd.decide) begin
         tgt_ff <= (speed_ff < RPM_W'(min_ff)) ? '0 : speed_ff;
      end
      if (cmd.filt1) begin
         p1_ff <= 51'(alpha_ff) * 51'(filt_ff[idx]);
      end
      if (cmd.filt2) begin
         p2_ff <= 51'(ALPHA_ONE - alpha_ff) * 51'({tgt_ff, 8'b0});
      end
   end

   // Channel state, sweep counter and update time
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            edge_ff[i]   <= '0;
            period_ff[i] <= '0;
            raw_ff[i]    <= '0;
            filt_ff[i]   <= '0;
         end
         last_upd_ff <= '0;
         shared_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         if (cmd.edge_wr && chan_ok) begin
            period_ff[idx] <= now_ff - edge_ff[idx];
            edge_ff[idx]   <= now_ff;
         end
         if (cmd.decide) begin
            raw_ff[idx] <= speed_ff;
         end
         if (cmd.filt3) begin
            filt_ff[idx] <= f_new;
            shared_ff    <= f_new[FILT_W-1:8];
         end
         if (cmd.ch_clear) begin
            cnt_ff <= '0;
         end else if (cmd.ch_next) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.upd_time) begin
            last_upd_ff <= now_ff;
         end
      end
   end

   // Result register, free again once the item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         ovalid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         ochan_ff   <= CHAN_W'(cnt_ff);
         oraw_ff    <= raw_ff[idx];
         ofilt_ff   <= filt_ff[idx][FILT_W-1:8];
         oshared_ff <= shared_ff;
         olast_ff   <= ~rest_hi;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {oshared_ff, ofilt_ff, oraw_ff, ochan_ff};
   assign rsp_tlast  = olast_ff;

   assign stat.is_update   = act_ff == ACT_UPDATE;
   assign stat.drop        = (updp_ff != '0) && (dt < TIME_W'(updp_ff));
   assign stat.div_done    = div_done;
   assign stat.ch_en       = en_vec[cnt_ff];
   assign stat.ch_end      = cnt_ff == IW'(CHANNELS - 1);
   assign stat.rest_none   = ~rest_hi;
   assign stat.period_zero = period_ff[idx] == '0;
   assign stat.skip_filter = spike | hold;
   assign stat.out_free    = ~ovalid_ff | rsp_tready;
endmodule

// ===== rtl/core/tach_ctrl.sv =====
// Controller state machine of the tachometer core: sequences the edge write,
// the alpha computation and the per-channel sweep. Depends on tach_pkg.
`timescale 1ns / 1ps
module tach_ctrl
   import tach_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ITEM   = 4'd1;
   localparam logic [3:0] S_KMUL   = 4'd2;
   localparam logic [3:0] S_XMUL   = 4'd3;
   localparam logic [3:0] S_ADIV   = 4'd4;
   localparam logic [3:0] S_AWAIT  = 4'd5;
   localparam logic [3:0] S_CHAN   = 4'd6;
   localparam logic [3:0] S_SWAIT  = 4'd7;
   localparam logic [3:0] S_LIM    = 4'd8;
   localparam logic [3:0] S_DECIDE = 4'd9;
   localparam logic [3:0] S_F1     = 4'd10;
   localparam logic [3:0] S_F2     = 4'd11;
   localparam logic [3:0] S_F3     = 4'd12;
   localparam logic [3:0] S_EMIT   = 4'd13;
   localparam logic [3:0] S_NEXT   = 4'd14;
   localparam logic [3:0] S_DONE   = 4'd15;

   logic [3:0] state_ff, state_in;

   assign req_tready = state_ff == S_IDLE;

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_ITEM;
            end
         end
         S_ITEM: begin
            if (!stat.is_update) begin
               cmd.edge_wr = 1'b1;
               state_in    = S_IDLE;
            end else if (stat.drop) begin
               state_in = S_IDLE;
            end else begin
               cmd.ch_clear = 1'b1;
               state_in     = S_KMUL;
            end
         end
         S_KMUL: begin
            cmd.k_mul = 1'b1;
            state_in  = S_XMUL;
         end
         S_XMUL: begin
            cmd.x_mul = 1'b1;
            state_in  = S_ADIV;
         end
         S_ADIV: begin
            cmd.div_alpha = 1'b1;
            state_in      = S_AWAIT;
         end
         S_AWAIT: begin
            if (stat.div_done) begin
               cmd.alpha_load = 1'b1;
               state_in       = S_CHAN;
            end
         end
         S_CHAN: begin
            if (!stat.ch_en) begin
               state_in = S_NEXT;
            end else if (stat.period_zero) begin
               cmd.speed_load = 1'b1;
               state_in       = S_LIM;
            end else begin
               cmd.div_speed = 1'b1;
               state_in      = S_SWAIT;
            end
         end
         S_SWAIT: begin
            if (stat.div_done) begin
               cmd.speed_load = 1'b1;
               state_in       = S_LIM;
            end
         end
         S_LIM: begin
            cmd.lim_mul = 1'b1;
            state_in    = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.skip_filter ? S_EMIT : S_F1;
         end
         S_F1: begin
            cmd.filt1 = 1'b1;
            state_in  = S_F2;
         end
         S_F2: begin
            cmd.filt2 = 1'b1;
            state_in  = S_F3;
         end
         S_F3: begin
            cmd.filt3 = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = stat.rest_none ? S_DONE : S_NEXT;
            end
         end
         S_NEXT: begin
            cmd.ch_next = 1'b1;
            state_in    = stat.ch_end ? S_DONE : S_CHAN;
         end
         S_DONE: begin
            cmd.upd_time = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== rtl/core/tachometer_rpm_filter_core.sv =====
// Top level of the tachometer RPM filter core: joins the controller and the
// datapath. Depends on tach_pkg, tach_ctrl and tach_dp.
//
//   Channel  Direction  Contents
//   req_     in         tuser: action; tdata: channel, time_us
//   rsp_     out        tdata: out_channel, raw_speed, filtered_speed, latest_shared;
//                       tlast: last
//   csr_     in         write enable, register index, write data
//
// An edge item updates its channel's edge time and period. An update item runs
// the alpha division, then a speed division per enabled channel with a nonzero
// period, on the 35-step shared divider. Synchronous reset clears control,
// CSR and channel state. The sweep waits while the result register is full.
`timescale 1ns / 1ps
module tachometer_rpm_filter_core
   import tach_pkg::*;
#(
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,  // channel[1:0], time_us[33:2], zero pad
   input  logic                  req_tuser,  // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [79:0]           rsp_tdata,  // out_channel, raw_speed, filtered_speed,
                                             // latest_shared
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   cmd_type  cmd;
   stat_type stat;

   tach_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tach_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_idx    (csr_idx),
      .csr_wdata  (csr_wdata),
      .in_action  (req_tuser),
      .in_channel (req_tdata[1:0]),
      .in_time    (req_tdata[33:2]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
